// ----- hdl/attribute_tlv_stream_parser_core_macros.svh -----
// Assertion helpers shared by the parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ATTRIBUTE_TLV_STREAM_PARSER_CORE_MACROS_SVH
`define ATTRIBUTE_TLV_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define ATSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atsp check failed");

// Next-cycle implication.
`define ATSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atsp check failed");

`endif

// ----- hdl/atsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package atsp_pkg;

  localparam logic [15:0] HEADER_BYTES = 16'd6;
  localparam logic [15:0] LENGTH_BYTES = 16'd2;
  localparam logic [15:0] ID_BYTES     = 16'd1;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  attr_id;
    logic [7:0]  value_byte;
    logic [15:0] byte_index;
    logic        last;
  } out_item_t;

  // Parser response for the item held in the input register.
  typedef struct packed {
    logic      emit;
    phase_t    phase;
    out_item_t item;
  } parse_res_t;

endpackage
`default_nettype wire

// ----- hdl/atsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface atsp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface atsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  attr_id;
  logic [7:0]  value_byte;
  logic [15:0] byte_index;
  logic        last;

  modport source (output valid, output attr_id, output value_byte, output byte_index,
                  output last, input ready);
  modport sink   (input valid, input attr_id, input value_byte, input byte_index,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/attribute_tlv_stream_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Notification attribute TLV stream parser. Feed the response byte stream one
// byte per transfer on in_ch (opcode 1); an opcode 0 transfer restarts the
// parser for a new response and produces nothing. After a restart the first
// five bytes are header and are dropped, the sixth is the first attribute id,
// then come a two-byte little-endian length and that many value bytes. Every
// value byte leaves on out_ch with its attribute id, its position from 0, and
// last set on the final byte; a zero-length attribute produces nothing.
// Throughput is one byte per clock while no waiting result holds it up: the
// parser state updates once per byte. A result passes through the input
// register, then the result register, before it is offered on out_ch. A
// result waiting on out_ch stalls only the byte behind it that would itself
// produce a result; header, id and length bytes keep flowing.
module attribute_tlv_stream_parser_core
  import atsp_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  atsp_in_if.sink   in_ch,
  atsp_out_if.source out_ch
);

`include "attribute_tlv_stream_parser_core_macros.svh"

  // Input register
  logic      stage_valid_r, stage_valid_nxt;
  in_item_t  stage_item_r;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  parse_res_t res;
  logic       out_free;
  logic       stage_fire;
  logic       in_ready;
  logic       in_fire;
  in_item_t   in_item;

  assign in_item = {in_ch.opcode, in_ch.data_byte};

  atsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (stage_fire),
    .item    (stage_item_r),
    .res     (res)
  );

  // The held byte retires when it needs no result slot or the slot is free.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign stage_fire = stage_valid_r && (!res.emit || out_free);
  assign in_ready   = !stage_valid_r || stage_fire;
  assign in_fire    = in_ch.valid && in_ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (stage_fire) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stage_fire && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_item_r <= in_item;
    end
    if (stage_fire && res.emit) begin
      out_item_r <= res.item;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.attr_id    = out_item_r.attr_id;
  assign out_ch.value_byte = out_item_r.value_byte;
  assign out_ch.byte_index = out_item_r.byte_index;
  assign out_ch.last       = out_item_r.last;

  // Results only come out of the value phase.
  `ATSP_ASSERT_NOW(a_emit_in_value, res.emit, res.phase == PH_VALUE)
  // The final value byte hands control back to the id phase.
  `ATSP_ASSERT_NEXT(a_last_to_id, stage_fire && res.emit && res.item.last, res.phase == PH_ID)
  // A restart always lands in the id phase.
  `ATSP_ASSERT_NEXT(a_restart_to_id, stage_fire && (stage_item_r.opcode == OP_RESTART),
                    res.phase == PH_ID)
  // Backpressure on the input only comes from a held byte.
  `ATSP_ASSERT_NOW(a_ready_low_held, !in_ready, stage_valid_r)

endmodule
`default_nettype wire

// ----- hdl/atsp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
module atsp_parser
  import atsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire in_item_t   item,
  output parse_res_t      res
);

  phase_t      phase_r,   phase_nxt;
  logic [15:0] seen_r,    seen_nxt;
  logic [15:0] wanted_r,  wanted_nxt;
  logic [7:0]  attr_r,    attr_nxt;
  logic [7:0]  len_lo_r,  len_lo_nxt;
  logic [15:0] seen_inc;
  logic [15:0] len_full;

  assign seen_inc = seen_r + 16'd1;
  assign len_full = {item.data_byte, len_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    seen_nxt   = seen_r;
    wanted_nxt = wanted_r;
    attr_nxt   = attr_r;
    len_lo_nxt = len_lo_r;
    if (item.opcode == OP_RESTART) begin
      phase_nxt  = PH_ID;
      seen_nxt   = '0;
      wanted_nxt = HEADER_BYTES;
      attr_nxt   = '0;
      len_lo_nxt = '0;
    end else begin
      case (phase_r)
        PH_VALUE: begin
          seen_nxt = seen_inc;
          if (seen_inc >= wanted_r) begin
            seen_nxt   = '0;
            wanted_nxt = ID_BYTES;
            phase_nxt  = PH_ID;
          end
        end
        PH_LEN: begin
          if (seen_r == '0) begin
            len_lo_nxt = item.data_byte;
          end
          seen_nxt = seen_inc;
          if (seen_inc >= LENGTH_BYTES) begin
            seen_nxt = '0;
            if (len_full == '0) begin
              wanted_nxt = ID_BYTES;
              phase_nxt  = PH_ID;
            end else begin
              wanted_nxt = len_full;
              phase_nxt  = PH_VALUE;
            end
          end
        end
        default: begin
          // identifier phase; the unused code behaves the same
          seen_nxt = seen_inc;
          if (seen_inc >= wanted_r) begin
            attr_nxt   = item.data_byte;
            seen_nxt   = '0;
            wanted_nxt = LENGTH_BYTES;
            phase_nxt  = PH_LEN;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.emit            = (item.opcode == OP_DATA) && (phase_r == PH_VALUE);
    res.phase           = phase_r;
    res.item.attr_id    = attr_r;
    res.item.value_byte = item.data_byte;
    res.item.byte_index = seen_r;
    res.item.last       = (seen_inc >= wanted_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ID;
      seen_r   <= '0;
      wanted_r <= HEADER_BYTES;
      attr_r   <= '0;
      len_lo_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      wanted_r <= wanted_nxt;
      attr_r   <= attr_nxt;
      len_lo_r <= len_lo_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- test/parse_result_checker.sv -----
`timescale 1ns / 1ps
module parse_result_checker
  import atsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  atsp_in_if   in_ch,
  atsp_out_if  out_ch,
  output int   n_mismatch,
  output int   n_waiting
);

  phase_t      phase;
  logic [15:0] seen;
  logic [15:0] wanted;
  logic [7:0]  attr;
  logic [7:0]  len_lo;
  out_item_t   expected_q[$];

  initial n_mismatch = 0;

  task automatic clear_parser();
    phase  = PH_ID;
    seen   = '0;
    wanted = HEADER_BYTES;
    attr   = '0;
    len_lo = '0;
  endtask

  // One accepted input byte; queues the value byte it produces, if any.
  task automatic parse_byte(input logic op, input logic [7:0] b);
    out_item_t   r;
    logic [15:0] len;
    if (op == OP_RESTART) begin
      clear_parser();
      return;
    end
    case (phase)
      PH_VALUE: begin
        r.attr_id    = attr;
        r.value_byte = b;
        r.byte_index = seen;
        seen         = seen + 16'd1;
        r.last       = (seen >= wanted);
        if (r.last) begin
          seen   = '0;
          wanted = ID_BYTES;
          phase  = PH_ID;
        end
        expected_q.push_back(r);
      end
      PH_LEN: begin
        if (seen == 16'd0) len_lo = b;
        seen = seen + 16'd1;
        if (seen >= LENGTH_BYTES) begin
          len  = {b, len_lo};
          seen = '0;
          if (len == 16'd0) begin
            wanted = ID_BYTES;
            phase  = PH_ID;
          end else begin
            wanted = len;
            phase  = PH_VALUE;
          end
        end
      end
      default: begin
        // header bytes and the id share this count
        seen = seen + 16'd1;
        if (seen >= wanted) begin
          attr   = b;
          seen   = '0;
          wanted = LENGTH_BYTES;
          phase  = PH_LEN;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      clear_parser();
      expected_q.delete();
    end else begin
      // results first: one accepted at this edge cannot stem from this edge's input
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.attr_id, out_ch.value_byte, out_ch.byte_index, out_ch.last};
        if (expected_q.size() == 0) begin
          $display("%0t: expected none, got id=%02h val=%02h idx=%0d last=%0b",
                   $time, got.attr_id, got.value_byte, got.byte_index, got.last);
          n_mismatch <= n_mismatch + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.attr_id !== want.attr_id || got.value_byte !== want.value_byte ||
              got.byte_index !== want.byte_index || got.last !== want.last) begin
            $display("%0t: expected id=%02h val=%02h idx=%0d last=%0b, got id=%02h val=%02h idx=%0d last=%0b",
                     $time, want.attr_id, want.value_byte, want.byte_index, want.last,
                     got.attr_id, got.value_byte, got.byte_index, got.last);
            n_mismatch <= n_mismatch + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.opcode, in_ch.data_byte);
    end
    n_waiting <= expected_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import atsp_pkg::*;

  // Data bytes in the run, with one long attribute whose length needs the high byte.
  localparam int          ITEMS    = 900;
  localparam logic [15:0] LONG_LEN = 16'h0123;

  // Opening sequence, run straight out of reset with no restart first:
  // five header bytes, a zero-length attribute, a one-byte attribute,
  // a three-byte attribute, a restart carrying a nonzero byte, and a
  // restart that lands in the middle of the header.
  localparam logic [8:0] DIRECTED[22] = '{
    {OP_DATA, 8'h00}, {OP_DATA, 8'hFF}, {OP_DATA, 8'h55}, {OP_DATA, 8'hAA},
    {OP_DATA, 8'h01},
    {OP_DATA, 8'hFF}, {OP_DATA, 8'h00}, {OP_DATA, 8'h00},
    {OP_DATA, 8'h00}, {OP_DATA, 8'h01}, {OP_DATA, 8'h00}, {OP_DATA, 8'hFF},
    {OP_DATA, 8'h80}, {OP_DATA, 8'h03}, {OP_DATA, 8'h00},
    {OP_DATA, 8'h00}, {OP_DATA, 8'h7F}, {OP_DATA, 8'h80},
    {OP_RESTART, 8'hFF},
    {OP_DATA, 8'h12}, {OP_DATA, 8'h34},
    {OP_RESTART, 8'h00}
  };

  logic clk;
  logic rst_n;
  bit   calm;       // no idling on either side
  bit   long_done;
  int   gap_pct;    // chance of a sender gap ahead of each transfer
  int   cut_left;   // bytes left before the current response is cut, -1 for none
  int   n_sent;     // accepted data bytes
  int   n_mismatch;
  int   n_waiting;

  atsp_in_if  in_ch();
  atsp_out_if out_ch();

  attribute_tlv_stream_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .n_mismatch (n_mismatch),
    .n_waiting  (n_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // This allows several times the duration of the slowest legal run of some 1k bytes.
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly short values; zero lengths are common, a few need the high byte.
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 8));
    if (r < 97) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(256, 300));
  endfunction

  // One transfer on in_ch. valid is only ever held high while waiting on
  // ready, so an early return for a cut response never repeats a byte.
  task automatic push_byte(input logic op, input logic [7:0] b);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_DATA) n_sent++;
  endtask

  // id, little-endian length, then the value bytes
  task automatic send_attribute(input logic [7:0] id, input logic [15:0] len);
    push_byte(OP_DATA, id);
    push_byte(OP_DATA, len[7:0]);
    push_byte(OP_DATA, len[15:8]);
    for (int i = 0; i < int'(len); i++) push_byte(OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Restart, five header bytes, then the attributes; the first id is the
  // sixth byte after the restart.
  task automatic send_response(input int n_attr, input bit with_long);
    push_byte(OP_RESTART, 8'($urandom_range(0, 255)));
    repeat (HEADER_BYTES - 1) push_byte(OP_DATA, 8'($urandom_range(0, 255)));
    for (int i = 0; i < n_attr; i++)
      send_attribute(8'($urandom_range(0, 255)),
                     (with_long && i == 0) ? LONG_LEN : pick_length());
  endtask

  // Hold the sender off until every predicted result has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
  endtask

  // Result side: ready bursts with random stalls.
  initial begin
    out_ch.ready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_RESTART;
    in_ch.data_byte <= 8'h00;
    rst_n           <= 1'b0;
    calm      = 1'b0;
    long_done = 1'b0;
    gap_pct   = 30;
    cut_left  = -1;
    n_sent    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) push_byte(DIRECTED[i][8], DIRECTED[i][7:0]);
    drain();

    while (n_sent < ITEMS) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      calm     = (n_sent > ITEMS - 120);
      cut_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
      if (!long_done && n_sent >= 300) begin
        // long attribute, never cut; then the sender waits for the backlog
        cut_left  = -1;
        send_response(1, 1'b1);
        long_done = 1'b1;
        drain();
      end else if ($urandom_range(0, 99) < 85) begin
        send_response($urandom_range(1, 6), 1'b0);
      end else begin
        // noise: random bytes with the odd restart
        repeat ($urandom_range(1, 20))
          push_byte(($urandom_range(0, 9) == 0) ? OP_RESTART : OP_DATA,
                    8'($urandom_range(0, 255)));
      end
    end

    drain();
    // spare cycles catch any stray result
    repeat (8) @(posedge clk);
    if (n_mismatch == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
